[src/follow_leader_chain_strip_macros.svh]
// Assertion helpers for the chain strip block.
`ifndef FOLLOW_LEADER_CHAIN_STRIP_MACROS_SVH
`define FOLLOW_LEADER_CHAIN_STRIP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FLL_ASSERT_NOW(label, clk, rst, cond, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FLL_ASSERT_NEXT(label, clk, rst, cond, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error(msg);

`endif

[src/fll_pkg.sv]
package fll_pkg;

   localparam int SEGMENTS_DEF = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_LINK_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEAD_WIDTH  = 2'd1;

   localparam logic [15:0] LINK_RESET  = 16'd2560;
   localparam logic [15:0] WIDTH_RESET = 16'd2560;

   localparam logic [14:0] ONE_Q14 = 15'd16384;

   // floor(v / 10) as (v * ceil(2^23 / 10)) >> 23, exact for v below 2^22.
   localparam logic [19:0] DIV10_MUL = 20'd838861;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
   } node_type;

   // Divide by 2^14, rounding to nearest with ties away from zero.
   function automatic logic signed [18:0] round_q14(input logic signed [33:0] p);
      logic [33:0] mag;
      logic [33:0] r;
      mag = p[33] ? 34'(-p) : 34'(p);
      r = (mag + 34'd8192) >> 14;
      return p[33] ? -$signed({1'b0, r[17:0]}) : $signed({1'b0, r[17:0]});
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      if (v > 26'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -26'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

endpackage

[src/fll_cell.sv]
module fll_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  fll_pkg::node_type node_in,
   output fll_pkg::node_type node_out
);

   fll_pkg::node_type node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
      end else if (shift) begin
         node_ff <= node_in;
      end
   end

   assign node_out = node_ff;

endmodule

[src/fll_sqrt.sv]
module fll_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [49:0] radicand,
   output logic        busy,
   output logic        done,
   output logic [24:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [49:0] v_ff;
   logic [49:0] res_ff;
   logic [49:0] bit_ff;
   logic [49:0] trial;
   logic        fits;

   // One result bit per cycle, restoring method.
   assign trial = res_ff + bit_ff;
   assign fits  = v_ff >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff == 50'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= 50'd1 << 48;
      end else if (busy_ff) begin
         if (fits) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = res_ff[24:0];

endmodule

[src/fll_div.sv]
module fll_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] numer,
   input  logic [24:0] denom,
   output logic        done,
   output logic [14:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [3:0]  cnt_ff;
   logic [39:0] rem_ff;
   logic [38:0] dsh_ff;
   logic [14:0] q_ff;
   logic        fits;

   // Shift-subtract, one quotient bit per cycle.
   assign fits = rem_ff >= {1'b0, dsh_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 4'd14;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= numer;
         dsh_ff <= {denom, 14'd0};
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - {1'b0, dsh_ff};
         end
         q_ff   <= {q_ff[13:0], fits};
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[src/follow_leader_chain_strip.sv]
// Follow-the-leader chain drawn as a strip of quads. Each accepted request word
// moves the head node to (req_root_x, req_root_y); the block then walks nodes 1
// to SEGMENTS, records each node's unit direction to its parent (Q1.14) and pulls
// any node farther than link_length back to that distance, rounded. Afterwards it
// returns SEGMENTS response words, one quad per segment from the head, with
// rsp_last_segment high on the final one. The node state lives in a ring of
// SEGMENTS cells that rotates by one place per node, so the computing logic only
// ever looks at the first cell. In the follow pass a node that has moved away from
// its parent waits on the square root and then on the direction dividers, which
// all nodes share; a node that sits on its parent skips both waits. The strip
// pass goes through a near, a far and an output step per segment, and it stalls
// on the output step while the receiver holds back a finished quad. A new
// request word is taken only once the previous update has produced all of its
// quads. Registers may be written at any time the block is idle; writes to
// unknown indexes are dropped.
module follow_leader_chain_strip #(
   parameter int SEGMENTS = fll_pkg::SEGMENTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [23:0]               req_root_x,
   input  logic signed [23:0]               req_root_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [5:0]                       rsp_segment_index,
   output logic signed [23:0]               rsp_near_left_x,
   output logic signed [23:0]               rsp_near_left_y,
   output logic signed [23:0]               rsp_near_right_x,
   output logic signed [23:0]               rsp_near_right_y,
   output logic signed [23:0]               rsp_far_right_x,
   output logic signed [23:0]               rsp_far_right_y,
   output logic signed [23:0]               rsp_far_left_x,
   output logic signed [23:0]               rsp_far_left_y,
   output logic                             rsp_last_segment,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fll_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                      csr_data
);

   localparam int CW = (SEGMENTS > 2) ? $clog2(SEGMENTS) : 1;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_A_LOAD = 4'd1;
   localparam logic [3:0] ST_A_SQ   = 4'd2;
   localparam logic [3:0] ST_A_SUM  = 4'd3;
   localparam logic [3:0] ST_A_SQRT = 4'd4;
   localparam logic [3:0] ST_A_DIV  = 4'd5;
   localparam logic [3:0] ST_A_PMUL = 4'd6;
   localparam logic [3:0] ST_A_PULL = 4'd7;
   localparam logic [3:0] ST_A_WB   = 4'd8;
   localparam logic [3:0] ST_B_NEAR = 4'd9;
   localparam logic [3:0] ST_B_FAR  = 4'd10;
   localparam logic [3:0] ST_B_OUT  = 4'd11;

   logic [3:0]          state_ff;
   logic [CW-1:0]       cnt_ff;
   logic [15:0]         link_ff;
   logic [15:0]         hwidth_ff;

   // Working registers of the follow pass.
   logic signed [23:0]  head_x_ff;
   logic signed [23:0]  head_y_ff;
   logic signed [23:0]  par_x_ff;
   logic signed [23:0]  par_y_ff;
   fll_pkg::node_type   cur_ff;
   fll_pkg::node_type   upd_ff;
   logic signed [24:0]  dx_ff;
   logic signed [24:0]  dy_ff;
   logic [48:0]         sqx_ff;
   logic [48:0]         sqy_ff;
   logic                pull_ff;
   logic signed [33:0]  pmx_ff;
   logic signed [33:0]  pmy_ff;

   // Working registers of the strip pass.
   logic signed [23:0]  near_x_ff;
   logic signed [23:0]  near_y_ff;
   logic [15:0]         wn_ff;
   logic [15:0]         wf_ff;
   logic signed [33:0]  pnx_ff;
   logic signed [33:0]  pny_ff;
   logic signed [33:0]  pfx_ff;
   logic signed [33:0]  pfy_ff;

   logic                rsp_valid_ff;
   logic [5:0]          seg_ff;
   logic signed [23:0]  nlx_ff, nly_ff, nrx_ff, nry_ff;
   logic signed [23:0]  frx_ff, fry_ff, flx_ff, fly_ff;
   logic                last_ff;

   fll_pkg::node_type   cell_out [SEGMENTS];
   fll_pkg::node_type   wrap;
   logic                ring_shift;

   logic                req_fire;
   logic                last;
   logic                out_free;
   logic [49:0]         d2;
   logic [31:0]         lim;
   logic signed [49:0]  sqx_p;
   logic signed [49:0]  sqy_p;
   logic                sqrt_start;
   logic                sqrt_busy;
   logic                sqrt_done;
   logic [24:0]         dist_len;
   logic [24:0]         abs_dx;
   logic [24:0]         abs_dy;
   logic                div_start;
   logic                divx_done;
   logic                divy_done;
   logic [14:0]         qx;
   logic [14:0]         qy;
   logic [14:0]         qx_c;
   logic [14:0]         qy_c;
   logic signed [16:0]  nx;
   logic signed [16:0]  ny;
   logic [15:0]         wf_eff;
   logic [18:0]         div10_num;
   logic [38:0]         div10_prod;
   logic signed [18:0]  onx, ony, ofx, ofy;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign last      = (cnt_ff == CW'(SEGMENTS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The node ring: cell 0 always holds the node being worked on.
   assign ring_shift = (state_ff == ST_A_WB) ||
                       (state_ff == ST_B_OUT && out_free);
   assign wrap = (state_ff == ST_A_WB) ? upd_ff : cell_out[0];

   for (genvar g = 0; g < SEGMENTS; g++) begin : g_cell
      if (g == SEGMENTS - 1) begin : g_tail
         fll_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (ring_shift),
            .node_in  (wrap),
            .node_out (cell_out[g])
         );
      end else begin : g_body
         fll_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (ring_shift),
            .node_in  (cell_out[g+1]),
            .node_out (cell_out[g])
         );
      end
   end

   // Distance to the parent, squared and exact.
   assign sqx_p = dx_ff * dx_ff;
   assign sqy_p = dy_ff * dy_ff;
   assign d2    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign lim   = link_ff * link_ff;

   assign sqrt_start = (state_ff == ST_A_SUM) && (d2 != 50'd0);

   fll_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (d2),
      .busy     (sqrt_busy),
      .done     (sqrt_done),
      .root     (dist_len)
   );

   // Rounded direction: (|d| * 2^14 + dist / 2) / dist, sign restored later.
   assign abs_dx    = dx_ff[24] ? 25'(-dx_ff) : 25'(dx_ff);
   assign abs_dy    = dy_ff[24] ? 25'(-dy_ff) : 25'(dy_ff);
   assign div_start = (state_ff == ST_A_SQRT) && sqrt_done;

   fll_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer ({1'b0, abs_dx, 14'd0} + 40'(dist_len >> 1)),
      .denom (dist_len),
      .done  (divx_done),
      .quot  (qx)
   );

   fll_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer ({1'b0, abs_dy, 14'd0} + 40'(dist_len >> 1)),
      .denom (dist_len),
      .done  (divy_done),
      .quot  (qy)
   );

   assign qx_c = (qx > fll_pkg::ONE_Q14) ? fll_pkg::ONE_Q14 : qx;
   assign qy_c = (qy > fll_pkg::ONE_Q14) ? fll_pkg::ONE_Q14 : qy;

   // The normal of the far node, and the tail's zero half-width.
   assign nx     = -{cell_out[0].dy[15], cell_out[0].dy};
   assign ny     = {cell_out[0].dx[15], cell_out[0].dx};
   assign wf_eff = last ? 16'd0 : wf_ff;

   assign div10_num  = {wf_ff, 3'd0} + 19'd5;
   assign div10_prod = div10_num * fll_pkg::DIV10_MUL;

   assign onx = fll_pkg::round_q14(pnx_ff);
   assign ony = fll_pkg::round_q14(pny_ff);
   assign ofx = fll_pkg::round_q14(pfx_ff);
   assign ofy = fll_pkg::round_q14(pfy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff   <= fll_pkg::LINK_RESET;
         hwidth_ff <= fll_pkg::WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fll_pkg::REG_LINK_LENGTH: link_ff   <= csr_data;
            fll_pkg::REG_HEAD_WIDTH:  hwidth_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_B_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_A_LOAD;
               end
            end
            ST_A_LOAD: state_ff <= ST_A_SQ;
            ST_A_SQ:   state_ff <= ST_A_SUM;
            ST_A_SUM:  state_ff <= (d2 == 50'd0) ? ST_A_WB : ST_A_SQRT;
            ST_A_SQRT: begin
               if (sqrt_done) begin
                  state_ff <= ST_A_DIV;
               end
            end
            ST_A_DIV: begin
               if (divx_done && divy_done) begin
                  state_ff <= ST_A_PMUL;
               end
            end
            ST_A_PMUL: state_ff <= ST_A_PULL;
            ST_A_PULL: state_ff <= ST_A_WB;
            ST_A_WB: begin
               if (last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_B_NEAR;
               end else begin
                  cnt_ff   <= cnt_ff + CW'(1);
                  state_ff <= ST_A_LOAD;
               end
            end
            ST_B_NEAR: state_ff <= ST_B_FAR;
            ST_B_FAR:  state_ff <= ST_B_OUT;
            ST_B_OUT: begin
               if (out_free) begin
                  if (last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     cnt_ff   <= cnt_ff + CW'(1);
                     state_ff <= ST_B_NEAR;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Datapath registers, no reset needed.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               head_x_ff <= req_root_x;
               head_y_ff <= req_root_y;
               par_x_ff  <= req_root_x;
               par_y_ff  <= req_root_y;
            end
         end
         ST_A_LOAD: begin
            cur_ff <= cell_out[0];
            dx_ff  <= {par_x_ff[23], par_x_ff} - {cell_out[0].x[23], cell_out[0].x};
            dy_ff  <= {par_y_ff[23], par_y_ff} - {cell_out[0].y[23], cell_out[0].y};
         end
         ST_A_SQ: begin
            sqx_ff <= sqx_p[48:0];
            sqy_ff <= sqy_p[48:0];
         end
         ST_A_SUM: begin
            // A node on top of its parent keeps position and direction.
            upd_ff  <= cur_ff;
            pull_ff <= d2 > {18'd0, lim};
         end
         ST_A_DIV: begin
            if (divx_done && divy_done) begin
               upd_ff.dx <= dx_ff[24] ? -$signed({1'b0, qx_c}) : $signed({1'b0, qx_c});
               upd_ff.dy <= dy_ff[24] ? -$signed({1'b0, qy_c}) : $signed({1'b0, qy_c});
            end
         end
         ST_A_PMUL: begin
            pmx_ff <= 34'(upd_ff.dx * $signed({1'b0, link_ff}));
            pmy_ff <= 34'(upd_ff.dy * $signed({1'b0, link_ff}));
         end
         ST_A_PULL: begin
            if (pull_ff) begin
               upd_ff.x <= fll_pkg::sat24(26'(par_x_ff) - 26'(fll_pkg::round_q14(pmx_ff)));
               upd_ff.y <= fll_pkg::sat24(26'(par_y_ff) - 26'(fll_pkg::round_q14(pmy_ff)));
            end
         end
         ST_A_WB: begin
            par_x_ff <= upd_ff.x;
            par_y_ff <= upd_ff.y;
            if (last) begin
               near_x_ff <= head_x_ff;
               near_y_ff <= head_y_ff;
               wn_ff     <= hwidth_ff;
               wf_ff     <= hwidth_ff;
            end
         end
         ST_B_NEAR: begin
            pnx_ff <= 34'(nx * $signed({1'b0, wn_ff}));
            pny_ff <= 34'(ny * $signed({1'b0, wn_ff}));
         end
         ST_B_FAR: begin
            pfx_ff <= 34'(nx * $signed({1'b0, wf_eff}));
            pfy_ff <= 34'(ny * $signed({1'b0, wf_eff}));
         end
         ST_B_OUT: begin
            if (out_free) begin
               seg_ff  <= 6'(cnt_ff);
               last_ff <= last;
               nlx_ff  <= fll_pkg::sat24(26'(near_x_ff) + 26'(onx));
               nly_ff  <= fll_pkg::sat24(26'(near_y_ff) + 26'(ony));
               nrx_ff  <= fll_pkg::sat24(26'(near_x_ff) - 26'(onx));
               nry_ff  <= fll_pkg::sat24(26'(near_y_ff) - 26'(ony));
               frx_ff  <= fll_pkg::sat24(26'(cell_out[0].x) - 26'(ofx));
               fry_ff  <= fll_pkg::sat24(26'(cell_out[0].y) - 26'(ofy));
               flx_ff  <= fll_pkg::sat24(26'(cell_out[0].x) + 26'(ofx));
               fly_ff  <= fll_pkg::sat24(26'(cell_out[0].y) + 26'(ofy));
               near_x_ff <= cell_out[0].x;
               near_y_ff <= cell_out[0].y;
               wn_ff     <= wf_ff;
               wf_ff     <= div10_prod[38:23];
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segment_index = seg_ff;
   assign rsp_near_left_x   = nlx_ff;
   assign rsp_near_left_y   = nly_ff;
   assign rsp_near_right_x  = nrx_ff;
   assign rsp_near_right_y  = nry_ff;
   assign rsp_far_right_x   = frx_ff;
   assign rsp_far_right_y   = fry_ff;
   assign rsp_far_left_x    = flx_ff;
   assign rsp_far_left_y    = fly_ff;
   assign rsp_last_segment  = last_ff;

`include "follow_leader_chain_strip_macros.svh"

   // An accepted request always starts the follow pass at the first node.
   `FLL_ASSERT_NEXT(a_req_starts, clock, reset, req_fire, state_ff == ST_A_LOAD && cnt_ff == '0, "request did not start the follow pass")

   // The last quad carries the tail segment's number.
   `FLL_ASSERT_NOW(a_last_index, clock, reset, rsp_valid && rsp_last_segment, rsp_segment_index == 6'(SEGMENTS - 1), "last quad has wrong segment number")

   // The square root unit only runs while the sequencer waits on it.
   `FLL_ASSERT_NOW(a_sqrt_owned, clock, reset, sqrt_busy, state_ff == ST_A_SQRT, "square root busy outside its wait state")

endmodule

[verif/tb_follow_leader_chain_strip.sv]
`timescale 1ns / 1ps

// Testbench for the follow-the-leader chain strip. Request words move the head
// node, and every update returns one quad word per segment. Each quad word is
// checked against a local model of the chain that is updated on every accepted
// request word.
module tb_follow_leader_chain_strip;

   localparam int SEGS = fll_pkg::SEGMENTS_DEF;
   localparam int NODES = SEGS + 1;
   localparam longint POS_HI = 64'sd8388607;
   localparam longint POS_LO = -64'sd8388608;
   localparam longint UNIT = 64'sd16384;

   // Indexes that name no register.
   localparam logic [fll_pkg::CSR_INDEX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [fll_pkg::CSR_INDEX_W-1:0] REG_SPARE_B = 2'd3;

   // One expected quad word: the corners are held in port order, from near left
   // to far left.
   typedef struct packed {
      logic [5:0]        seg;
      logic [7:0][23:0]  corner;
      logic              last;
   } quad_type;

   typedef struct {
      logic signed [23:0] x;
      logic signed [23:0] y;
      bit                 at_origin;   // expected quads are all zero
   } head_move_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [23:0] req_root_x = '0;
   logic signed [23:0] req_root_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_segment_index;
   logic signed [23:0] rsp_near_left_x, rsp_near_left_y;
   logic signed [23:0] rsp_near_right_x, rsp_near_right_y;
   logic signed [23:0] rsp_far_right_x, rsp_far_right_y;
   logic signed [23:0] rsp_far_left_x, rsp_far_left_y;
   logic rsp_last_segment;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [fll_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   // The chain as the block should hold it, plus its two registers.
   longint chain_x[NODES];
   longint chain_y[NODES];
   longint chain_dx[NODES];
   longint chain_dy[NODES];
   longint link_len;
   longint half_width;

   quad_type quad_q[$];
   int errors = 0;
   bit no_idle = 1'b0;
   longint last_x = 0;
   longint last_y = 0;

   always #6 clock = ~clock;

   follow_leader_chain_strip u_dut (.*);

   function automatic longint div_near(longint num, longint den);
      if (num >= 0) begin
         return (num + den / 2) / den;
      end
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint clip_pos(longint v);
      if (v > POS_HI) begin
         return POS_HI;
      end else if (v < POS_LO) begin
         return POS_LO;
      end
      return v;
   endfunction

   function automatic longint clip_unit(longint v);
      if (v > UNIT) begin
         return UNIT;
      end else if (v < -UNIT) begin
         return -UNIT;
      end
      return v;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint res;
      longint bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   // Moves the head, lets every node follow its parent and queues the quads.
   task automatic follow_and_stroke(input logic signed [23:0] hx, input logic signed [23:0] hy);
      longint ddx, ddy, d2, dlen, wn, wf, wfar, nx, ny, onx, ony, ofx, ofy;
      quad_type q;
      chain_x[0] = longint'(hx);
      chain_y[0] = longint'(hy);
      for (int k = 1; k < NODES; k++) begin
         ddx = chain_x[k-1] - chain_x[k];
         ddy = chain_y[k-1] - chain_y[k];
         d2 = ddx * ddx + ddy * ddy;
         // A node sitting on its parent keeps its old direction and stays put.
         if (d2 != 0) begin
            dlen = int_sqrt(d2);
            chain_dx[k] = clip_unit(div_near(ddx * UNIT, dlen));
            chain_dy[k] = clip_unit(div_near(ddy * UNIT, dlen));
            if (d2 > link_len * link_len) begin
               chain_x[k] = clip_pos(chain_x[k-1] - div_near(chain_dx[k] * link_len, UNIT));
               chain_y[k] = clip_pos(chain_y[k-1] - div_near(chain_dy[k] * link_len, UNIT));
            end
         end
      end
      wn = half_width;
      wf = half_width;
      for (int k = 0; k < SEGS; k++) begin
         nx = -chain_dy[k+1];
         ny = chain_dx[k+1];
         wfar = (k + 1 == SEGS) ? 0 : wf;
         onx = div_near(nx * wn, UNIT);
         ony = div_near(ny * wn, UNIT);
         ofx = div_near(nx * wfar, UNIT);
         ofy = div_near(ny * wfar, UNIT);
         q.seg = 6'(k);
         q.corner[0] = 24'(clip_pos(chain_x[k] + onx));
         q.corner[1] = 24'(clip_pos(chain_y[k] + ony));
         q.corner[2] = 24'(clip_pos(chain_x[k] - onx));
         q.corner[3] = 24'(clip_pos(chain_y[k] - ony));
         q.corner[4] = 24'(clip_pos(chain_x[k+1] - ofx));
         q.corner[5] = 24'(clip_pos(chain_y[k+1] - ofy));
         q.corner[6] = 24'(clip_pos(chain_x[k+1] + ofx));
         q.corner[7] = 24'(clip_pos(chain_y[k+1] + ofy));
         q.last = (k == SEGS - 1);
         quad_q.push_back(q);
         wn = wf;
         wf = (8 * wf + 5) / 10;
      end
   endtask

   // Sends one request word and waits until the block takes it. The sender
   // idles now and then before raising valid, and drops valid after each word.
   task automatic send_head(input logic signed [23:0] hx, input logic signed [23:0] hy,
                            input bit at_origin);
      quad_type z;
      while (!no_idle && $urandom_range(99) < 6) @(posedge clock);
      req_valid <= 1'b1;
      req_root_x <= hx;
      req_root_y <= hy;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      follow_and_stroke(hx, hy);
      last_x = longint'(hx);
      last_y = longint'(hy);
      // With the whole chain on the origin every corner is zero, so the
      // expected quads are typed in directly.
      if (at_origin) begin
         for (int k = 0; k < SEGS; k++) begin
            z = '0;
            z.seg = 6'(k);
            z.last = (k == SEGS - 1);
            quad_q[quad_q.size() - SEGS + k] = z;
         end
      end
      @(posedge clock);
   endtask

   // Registers are only written once the last quad word has come back.
   task automatic write_reg(input logic [fll_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] val);
      wait (quad_q.size() == 0);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == fll_pkg::REG_LINK_LENGTH) begin
         link_len = longint'(val);
      end else if (idx == fll_pkg::REG_HEAD_WIDTH) begin
         half_width = longint'(val);
      end
   endtask

   // Response side: the receiver stalls now and then, and every accepted
   // word is compared with the oldest expected quad.
   always @(posedge clock) begin
      quad_type want;
      quad_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 6);
         if (rsp_valid && rsp_ready) begin
            got.seg = rsp_segment_index;
            got.corner = {rsp_far_left_y, rsp_far_left_x, rsp_far_right_y, rsp_far_right_x,
                          rsp_near_right_y, rsp_near_right_x, rsp_near_left_y,
                          rsp_near_left_x};
            got.last = rsp_last_segment;
            if (quad_q.size() == 0) begin
               $display("%0t: unexpected quad word, segment %0d", $time, got.seg);
               errors++;
            end else begin
               want = quad_q.pop_front();
               if (want.seg !== got.seg) begin
                  $display("%0t: segment_index expected %0d actual %0d", $time,
                           want.seg, got.seg);
                  errors++;
               end
               for (int i = 0; i < 8; i++) begin
                  if (want.corner[i] !== got.corner[i]) begin
                     $display("%0t: segment %0d corner %0d expected %0d actual %0d", $time,
                              want.seg, i, $signed(want.corner[i]), $signed(got.corner[i]));
                     errors++;
                  end
               end
               if (want.last !== got.last) begin
                  $display("%0t: last_segment expected %0d actual %0d", $time,
                           want.last, got.last);
                  errors++;
               end
            end
         end
      end
   end

   // Directed rows: the start at the origin, full-scale corners that
   // saturate, repeats of one point, and short and long hops.
   head_move_type moves[20];

   initial begin
      moves[0]  = '{24'sd0, 24'sd0, 1'b1};
      moves[1]  = '{24'sd0, 24'sd0, 1'b1};
      moves[2]  = '{24'sd2560, 24'sd0, 1'b0};
      moves[3]  = '{24'sd2560, 24'sd0, 1'b0};
      moves[4]  = '{24'sd8388607, 24'sd8388607, 1'b0};
      moves[5]  = '{-24'sd8388608, -24'sd8388608, 1'b0};
      moves[6]  = '{24'sd8388607, -24'sd8388608, 1'b0};
      moves[7]  = '{-24'sd8388608, 24'sd8388607, 1'b0};
      moves[8]  = '{24'sd100, -24'sd300, 1'b0};
      moves[9]  = '{24'sd1, 24'sd0, 1'b0};
      moves[10] = '{24'sd5000, 24'sd5000, 1'b0};
      moves[11] = '{-24'sd5000, 24'sd5000, 1'b0};
      moves[12] = '{-24'sd5000, 24'sd5000, 1'b0};
      moves[13] = '{24'sd8388607, 24'sd0, 1'b0};
      moves[14] = '{24'sd0, -24'sd8388608, 1'b0};
      moves[15] = '{24'sd40000, 24'sd0, 1'b0};
      moves[16] = '{24'sd40000, 24'sd30000, 1'b0};
      moves[17] = '{-24'sd8388608, -24'sd8388608, 1'b0};
      moves[18] = '{24'sd8388607, 24'sd8388607, 1'b0};
      moves[19] = '{24'sd0, 24'sd0, 1'b0};
   end

   // Main sequence: reset, the directed rows under three register settings,
   // then random phases each with new register values.
   initial begin
      longint nxp, nyp;
      int pick, span;
      for (int k = 0; k < NODES; k++) begin
         chain_x[k] = 0;
         chain_y[k] = 0;
         chain_dx[k] = 0;
         chain_dy[k] = 0;
      end
      link_len = longint'(fll_pkg::LINK_RESET);
      half_width = longint'(fll_pkg::WIDTH_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 10; i++) send_head(moves[i].x, moves[i].y, moves[i].at_origin);
      write_reg(fll_pkg::REG_LINK_LENGTH, 16'd0);
      write_reg(fll_pkg::REG_HEAD_WIDTH, 16'hFFFF);
      for (int i = 10; i < 15; i++) send_head(moves[i].x, moves[i].y, 1'b0);
      write_reg(fll_pkg::REG_LINK_LENGTH, 16'hFFFF);
      write_reg(fll_pkg::REG_HEAD_WIDTH, 16'd0);
      // Unknown indexes must leave both registers alone.
      write_reg(REG_SPARE_A, 16'h5555);
      write_reg(REG_SPARE_B, 16'hAAAA);
      for (int i = 15; i < 20; i++) send_head(moves[i].x, moves[i].y, 1'b0);

      for (int ph = 0; ph < 5; ph++) begin
         unique case (ph)
            0: begin
               write_reg(fll_pkg::REG_LINK_LENGTH, 16'd1);
               write_reg(fll_pkg::REG_HEAD_WIDTH, 16'd2560);
            end
            1: begin
               write_reg(fll_pkg::REG_LINK_LENGTH, fll_pkg::LINK_RESET);
               write_reg(fll_pkg::REG_HEAD_WIDTH, fll_pkg::WIDTH_RESET);
            end
            default: begin
               write_reg(fll_pkg::REG_LINK_LENGTH, 16'($urandom_range(16'hFFFF)));
               write_reg(fll_pkg::REG_HEAD_WIDTH, 16'($urandom_range(16'hFFFF)));
            end
         endcase
         no_idle = (ph == 2);
         for (int i = 0; i < 44; i++) begin
            // Let the block drain completely once before going on.
            if (ph == 3 && i == 20) wait (quad_q.size() == 0);
            pick = $urandom_range(99);
            if (pick < 80) begin
               // A head that wanders, so the chain is pulled taut and bends.
               span = ($urandom_range(3) == 0) ? 40000 : 4096;
               nxp = clip_pos(last_x + $urandom_range(2 * span) - span);
               nyp = clip_pos(last_y + $urandom_range(2 * span) - span);
            end else if (pick < 92) begin
               nxp = longint'($signed(24'($urandom())));
               nyp = longint'($signed(24'($urandom())));
            end else begin
               nxp = last_x;
               nyp = last_y;
            end
            send_head(24'(nxp), 24'(nyp), 1'b0);
         end
      end
      no_idle = 1'b0;

      wait (quad_q.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/fll_pkg.sv
src/fll_cell.sv
src/fll_sqrt.sv
src/fll_div.sv
src/follow_leader_chain_strip.sv
verif/tb_follow_leader_chain_strip.sv
